/* design/tdpt_pkg.sv */
// Package for the trial-division prime test unit: widths, FSM state type,
// and the request/status structs between the sequencer and the divider.
// No dependencies.
package tdpt_pkg;

    // Width of the candidate value
    localparam int VALUE_BITS = 31;
    // Trial divisor width: holds the first divisor whose square exceeds any candidate
    localparam int DIV_BITS   = VALUE_BITS / 2 + 2;
    // Running square of the divisor, one bit of headroom over the candidate
    localparam int SQ_BITS    = VALUE_BITS + 1;
    // Bit counter of the serial divider
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_OUT
    } t_state;

    // Sequencer to divider
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [DIV_BITS-1:0]   divisor;
    } t_div_req;

    // Divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_div_sts;

endpackage

/* design/trial_division_prime_test_unit.sv */
// Top level of the trial-division prime test unit: sequencer, divisor and
// square registers, result register. Depends on tdpt_pkg and tdpt_divider.
//
// Takes one 31-bit candidate word and returns one word with prime_flag set if
// it is prime. Trial divisors run 2, 3, 4, ... while divisor squared does not
// exceed the candidate; the square is kept as a running sum, so no multiplier
// is used. Every remainder comes from one shared serial divider that retires
// one bit per cycle. Zero, one, two and three are settled without a division.
// One item is in work at a time; o_ready is low from acceptance until the
// result word is taken.
module trial_division_prime_test_unit import tdpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_candidate,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_prime_flag
);

    t_state                r_state;
    t_state                n_state;
    logic [VALUE_BITS-1:0] r_n;
    logic [DIV_BITS-1:0]   r_d;
    logic [SQ_BITS-1:0]    r_sq;
    logic                  r_flag;

    logic [VALUE_BITS-1:0] n_n;
    logic [DIV_BITS-1:0]   n_d;
    logic [SQ_BITS-1:0]    n_sq;
    logic                  n_flag;

    logic                  below_two;
    logic                  sq_over;
    t_div_req              div_req;
    t_div_sts              div_sts;

    assign below_two = (r_n[VALUE_BITS-1:1] == '0);
    assign sq_over   = (r_sq > {1'b0, r_n});

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (below_two || sq_over) n_state = S_OUT;
                else                      n_state = S_DIV;
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (div_sts.rem_zero) n_state = S_OUT;
                    else                  n_state = S_CHECK;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        n_n              = r_n;
        n_d              = r_d;
        n_sq             = r_sq;
        n_flag           = r_flag;
        div_req.start    = 1'b0;
        div_req.dividend = r_n;
        div_req.divisor  = r_d;
        o_ready          = 1'b0;
        o_valid          = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_n     = i_candidate;
                n_d     = DIV_BITS'(2);
                n_sq    = SQ_BITS'(4);
            end
            S_CHECK: begin
                if (below_two) begin
                    n_flag = 1'b0;
                end else if (sq_over) begin
                    n_flag = 1'b1;
                end else begin
                    div_req.start = 1'b1;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    if (div_sts.rem_zero) begin
                        n_flag = 1'b0;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_d  = r_d + 1'b1;
                        n_sq = r_sq + SQ_BITS'({r_d, 1'b1});
                    end
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_flag <= n_flag;
    end

    assign o_prime_flag = r_flag;

    tdpt_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    // Divider is never left running outside a trial
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !div_sts.busy)
        else $error("divider busy outside a trial");

    // A started trial keeps the divider busy on the next cycle
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (div_sts.busy && r_state == S_DIV))
        else $error("divider did not start");

    // Zero and one finish at once as not prime
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && below_two) |=> (r_state == S_OUT && !r_flag))
        else $error("zero or one not reported composite");

    // Running square tracks the divisor: never below it while searching
    a_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_sq >= SQ_BITS'(r_d)))
        else $error("running square out of step");

endmodule

/* design/tdpt_divider.sv */
// Shared restoring divider: one dividend bit per cycle, remainder only.
// Depends on tdpt_pkg.
module tdpt_divider import tdpt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_sts o_sts
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [DIV_BITS-1:0]   r_rem;
    logic [DIV_BITS-1:0]   r_div;

    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;
    logic [DIV_BITS-1:0]   n_rem;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_shift[VALUE_BITS-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[DIV_BITS-1:0];
        end else begin
            n_rem = trial[DIV_BITS-1:0];
        end
    end

    // Control: busy while the dividend bits are shifted through, done pulses once at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifter, partial remainder, latched divisor
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shift <= i_req.dividend;
            r_rem   <= '0;
            r_div   <= i_req.divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.rem_zero = (r_rem == '0);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for trial_division_prime_test_unit.
// Depends on tdpt_pkg and the unit's RTL; each result word is checked against
// a trial-division primality predictor kept in a small scoreboard class.
module testbench import tdpt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF       = 4;
    localparam int          RESET_CYCLES   = 9;
    localparam int          IDLE_PERCENT   = 37;
    localparam int          RANDOM_WORDS   = 80;
    localparam int          RX_HOLD_CYCLES = 600;
    localparam int          DRAIN_CYCLES   = 64;
    localparam longint      CYCLE_LIMIT    = 12_000_000;
    localparam int unsigned SMALL_MAX      = 4095;
    localparam int unsigned MEDIUM_MAX     = 262143;
    localparam int unsigned VALUE_MAX      = (1 << VALUE_BITS) - 1;

    typedef logic [VALUE_BITS-1:0] t_value;

    // Holds predicted flags for accepted words and checks result words
    class prime_scoreboard;
        bit          flag_queue[$];
        t_value      cand_queue[$];
        int unsigned mismatches;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned primes_in;

        // Divides by 2, 3, 4, ... while d * d <= n, stops at first exact divisor
        function bit trial_division_prime(t_value value);
            longint unsigned n;
            longint unsigned d;
            n = longint'(value);
            if (n < 2) return 1'b0;
            for (d = 2; d <= n / d; d++) begin
                if (n % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int unsigned outstanding();
            return flag_queue.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task note_candidate(t_value cand);
            bit flag;
            flag = trial_division_prime(cand);
            flag_queue.push_back(flag);
            cand_queue.push_back(cand);
            words_in++;
            if (flag) primes_in++;
        endtask

        task check_flag(logic flag);
            bit     want;
            t_value cand;
            words_out++;
            if (flag_queue.size() == 0) begin
                report_mismatch($sformatf("result word %b with no candidate pending", flag));
            end else begin
                want = flag_queue.pop_front();
                cand = cand_queue.pop_front();
                if (flag !== want)
                    report_mismatch($sformatf("candidate %0d: prime_flag %b, want %b",
                                              cand, flag, want));
            end
        endtask
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_value i_candidate;
    logic   o_valid;
    logic   i_ready;
    logic   o_prime_flag;

    prime_scoreboard sb;
    bit              rst_done;
    bit              no_idle;
    longint          cycle_count;

    trial_division_prime_test_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_candidate  (i_candidate),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_prime_flag (o_prime_flag)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Offer one candidate word, random gaps ahead of it; returns on the accept edge
    task automatic send_candidate(t_value cand);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid     <= 1'b0;
            i_candidate <= t_value'($urandom);
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_candidate <= cand;
        do @(posedge i_clk); while (!o_ready);
        sb.note_candidate(cand);
    endtask

    // Mostly small values; large ones carry a small factor so they finish fast
    function automatic t_value pick_candidate();
        int unsigned     roll;
        int unsigned     factor;
        int unsigned     upper;
        longint unsigned product;
        roll = $urandom_range(99);
        if (roll < 60) return t_value'($urandom_range(SMALL_MAX));
        if (roll < 75) return t_value'($urandom_range(MEDIUM_MAX));
        if (roll < 95) begin
            factor  = $urandom_range(97, 2);
            upper   = VALUE_MAX / factor;
            product = longint'(factor) * longint'($urandom_range(upper, upper / 2));
            return t_value'(product);
        end
        // Noise: any width, forced even
        return t_value'($urandom) & ~t_value'(1);
    endfunction

    // Receiver: long hold first so the unit backs up, then random ready
    initial begin : sink
        int hold;
        i_ready <= 1'b0;
        wait (rst_done);
        for (hold = 0; hold < RX_HOLD_CYCLES; hold++) @(posedge i_clk);
        forever begin
            i_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_flag(o_prime_flag);
        end
    end

    // Stimulus
    initial begin : source
        int unsigned directed[$];
        int          k;
        sb          = new();
        rst_done    = 1'b0;
        no_idle     = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_candidate <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // Zero and one, two and three, square boundaries, field extremes
        directed = '{0, 1, 2, 3, 4, 5, 8, 9, 25, 49, 2209, 4093, 4096,
                     65521, 65536, 1 << (VALUE_BITS - 1), (1 << (VALUE_BITS - 1)) - 1,
                     32'h5555_5555, 32'h2AAA_AAAA,
                     46340 * 46340, VALUE_MAX - 1, VALUE_MAX};
        foreach (directed[i]) send_candidate(t_value'(directed[i]));

        // Random part, with a middle stretch where neither side idles
        for (k = 0; k < RANDOM_WORDS; k++) begin
            no_idle = (k >= 35 && k < 65);
            send_candidate(pick_candidate());
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d candidate words (%0d prime), %0d result words checked",
                 sb.words_in, sb.primes_in, sb.words_out);
        $display("included zero, one, two, three, square boundaries and the largest prime");
        if (sb.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tdpt_pkg.sv
design/tdpt_divider.sv
design/trial_division_prime_test_unit.sv
tb/testbench.sv
